// ===== hdl/vfv_pkg.sv =====
// ---------------------------------------------------------------------------
// vfv_pkg
// shared types and constants of the voxel face visibility core
// ---------------------------------------------------------------------------
`default_nettype none

package vfv_pkg;

    // grid geometry, one row of the occupancy ram holds all cells along x
    localparam int MAX_DIM = 16;
    localparam int COORD_W = $clog2(MAX_DIM);
    localparam int DIM_W   = COORD_W + 1;
    localparam int ROW_W   = 2 * COORD_W;
    localparam int ROWS    = MAX_DIM * MAX_DIM;
    localparam int FACES   = 6;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIM_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_Z = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

    // sequencer steps
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_WB   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_LAST = 3'd5;

    // face bit positions in the mask
    localparam int FACE_PX = 0;
    localparam int FACE_NX = 1;
    localparam int FACE_PY = 2;
    localparam int FACE_NY = 3;
    localparam int FACE_PZ = 4;
    localparam int FACE_NZ = 5;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    typedef struct packed {
        logic               re;
        logic               we;
        logic [ROW_W-1:0]   addr;
        logic [MAX_DIM-1:0] wdata;
    } t_ram_req;

endpackage

`default_nettype wire

// ===== hdl/vfv_occ_ram.sv =====
// ---------------------------------------------------------------------------
// vfv_occ_ram
// occupancy row memory, one row per (y, z), with per-row valid bits
// ---------------------------------------------------------------------------
`default_nettype none

module vfv_occ_ram
    import vfv_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_ram_req           i_req,
    output logic [MAX_DIM-1:0]      o_rd_data
);

    logic [MAX_DIM-1:0] r_mem [ROWS];
    logic [ROWS-1:0]    r_vld;
    logic [MAX_DIM-1:0] r_rd_q;
    logic               r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_q <= r_mem[i_req.addr];
        end
    end

    // row never written reads as empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_vld[i_req.addr] <= 1'b1;
            end
            if (i_req.re) begin
                r_rd_vld <= r_vld[i_req.addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_q : '0;

endmodule

`default_nettype wire

// ===== hdl/voxel_face_visibility_core.sv =====
// ---------------------------------------------------------------------------
// voxel_face_visibility_core
// occupancy grid of one voxel chunk with write and face visibility requests
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Occupancy lives in
// a 256 x 16 row memory (one row per y,z pair, x selects the bit) with a
// registered read; per-row valid bits cleared at reset make the whole grid
// read empty right away, so there is no clearing pass. A write is a
// read-modify-write of its row: busy stays high while the row is read and
// written back, and the result shows in the cycle in which busy falls. A
// query reads its own row and the four y/z neighbor rows through the single
// read port: busy stays high until the last row has come back, and the
// result shows in the cycle in which busy falls. A request whose coordinate
// lies outside the chunk never raises busy and shows its result in the next
// cycle, so such requests can follow back to back. Each request gives one
// result on o_face_mask / o_error, marked by o_done for exactly one cycle,
// and a new request may be taken in that same cycle; the receiver cannot
// stall. Dimension registers are written through i_cfg_* while the core is
// idle; the user is bound to this, the core itself does not enforce it.
`default_nettype none

module voxel_face_visibility_core
    import vfv_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [DIM_W-1:0]     i_cfg_data,
    // request
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 i_cmd,
    input  wire logic [COORD_W-1:0]   i_coord_x,
    input  wire logic [COORD_W-1:0]   i_coord_y,
    input  wire logic [COORD_W-1:0]   i_coord_z,
    input  wire logic                 i_solid,
    input  wire logic [FACES-1:0]     i_boundary_solid,
    // result
    output logic                      o_done,
    output logic [FACES-1:0]          o_face_mask,
    output logic                      o_error
);

    // saturate a dimension register to the grid size
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        return (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
    endfunction

    t_state             r_state, n_state;
    logic [STEP_W-1:0]  r_step;
    logic [DIM_W-1:0]   r_dim_x, r_dim_y, r_dim_z;
    t_cmd               r_cmd;
    logic [COORD_W-1:0] r_x, r_y, r_z;
    logic               r_solid;
    logic [FACES-1:0]   r_bnd;
    logic [FACES-1:0]   r_mask, n_mask;
    logic               r_done, n_done;
    logic [FACES-1:0]   r_face_mask, n_face_mask;
    logic               r_error, n_error;

    logic [DIM_W-1:0]   dx, dy, dz;
    logic               accept;
    logic               in_err;
    logic               edge_px, edge_nx, edge_py, edge_ny, edge_pz, edge_nz;
    logic [COORD_W-1:0] x_p1, x_m1, y_p1, y_m1, z_p1, z_m1;
    logic [MAX_DIM-1:0] rd_row;
    logic [MAX_DIM-1:0] wr_row;
    t_ram_req           ram_req;

    assign dx = eff_dim(r_dim_x);
    assign dy = eff_dim(r_dim_y);
    assign dz = eff_dim(r_dim_z);

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // coordinate range check on the incoming request
    assign in_err = ({1'b0, i_coord_x} >= dx) || ({1'b0, i_coord_y} >= dy)
                 || ({1'b0, i_coord_z} >= dz);

    // chunk edges of the held cell
    assign edge_px = ({1'b0, r_x} + DIM_W'(1)) >= dx;
    assign edge_nx = (r_x == '0);
    assign edge_py = ({1'b0, r_y} + DIM_W'(1)) >= dy;
    assign edge_ny = (r_y == '0);
    assign edge_pz = ({1'b0, r_z} + DIM_W'(1)) >= dz;
    assign edge_nz = (r_z == '0);

    // neighbor coordinates, a wrap only happens where the edge decides
    assign x_p1 = r_x + COORD_W'(1);
    assign x_m1 = r_x - COORD_W'(1);
    assign y_p1 = r_y + COORD_W'(1);
    assign y_m1 = r_y - COORD_W'(1);
    assign z_p1 = r_z + COORD_W'(1);
    assign z_m1 = r_z - COORD_W'(1);

    // configuration writes, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_x <= DIM_RESET;
            r_dim_y <= DIM_RESET;
            r_dim_z <= DIM_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_DIM_X) begin
                r_dim_x <= i_cfg_data;
            end
            if (i_cfg_idx == REG_DIM_Y) begin
                r_dim_y <= i_cfg_data;
            end
            if (i_cfg_idx == REG_DIM_Z) begin
                r_dim_z <= i_cfg_data;
            end
        end
    end

    // request capture, payload only
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_x     <= i_coord_x;
            r_y     <= i_coord_y;
            r_z     <= i_coord_z;
            r_solid <= i_solid;
            r_bnd   <= i_boundary_solid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && !in_err) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if ((r_cmd == CMD_WRITE && r_step == STEP_WB) || r_step == STEP_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // write data: held row with the addressed bit replaced
    always_comb begin
        wr_row        = rd_row;
        wr_row[r_x]   = r_solid;
    end

    // sequencer outputs: ram requests, face collection, result
    always_comb begin
        ram_req       = '0;
        n_mask        = r_mask;
        n_done        = 1'b0;
        n_face_mask   = r_face_mask;
        n_error       = r_error;
        unique case (r_state)
            ST_IDLE: begin
                n_mask = '0;
                if (accept && in_err) begin
                    n_done      = 1'b1;
                    n_face_mask = '0;
                    n_error     = 1'b1;
                end
            end
            ST_RUN: begin
                // row issue: own row, then +y, -y, +z, -z
                unique case (r_step)
                    3'd0: begin
                        ram_req.re   = 1'b1;
                        ram_req.addr = {r_z, r_y};
                    end
                    3'd1: begin
                        ram_req.re   = (r_cmd == CMD_QUERY);
                        ram_req.addr = {r_z, y_p1};
                    end
                    3'd2: begin
                        ram_req.re   = 1'b1;
                        ram_req.addr = {r_z, y_m1};
                    end
                    3'd3: begin
                        ram_req.re   = 1'b1;
                        ram_req.addr = {z_p1, r_y};
                    end
                    3'd4: begin
                        ram_req.re   = 1'b1;
                        ram_req.addr = {z_m1, r_y};
                    end
                    default: begin
                        ram_req.re   = 1'b0;
                    end
                endcase

                // row read one step earlier arrives now
                unique case (r_step)
                    3'd1: begin
                        n_mask[FACE_PX] = edge_px ? !r_bnd[FACE_PX] : !rd_row[x_p1];
                        n_mask[FACE_NX] = edge_nx ? !r_bnd[FACE_NX] : !rd_row[x_m1];
                    end
                    3'd2: n_mask[FACE_PY] = edge_py ? !r_bnd[FACE_PY] : !rd_row[r_x];
                    3'd3: n_mask[FACE_NY] = edge_ny ? !r_bnd[FACE_NY] : !rd_row[r_x];
                    3'd4: n_mask[FACE_PZ] = edge_pz ? !r_bnd[FACE_PZ] : !rd_row[r_x];
                    3'd5: n_mask[FACE_NZ] = edge_nz ? !r_bnd[FACE_NZ] : !rd_row[r_x];
                    default: n_mask = r_mask;
                endcase

                if (r_cmd == CMD_WRITE) begin
                    // read-modify-write of the own row
                    if (r_step == STEP_WB) begin
                        ram_req.re    = 1'b0;
                        ram_req.we    = 1'b1;
                        ram_req.addr  = {r_z, r_y};
                        ram_req.wdata = wr_row;
                        n_done        = 1'b1;
                        n_face_mask   = '0;
                        n_error       = 1'b0;
                    end
                end else if (r_step == STEP_LAST) begin
                    n_done      = 1'b1;
                    n_face_mask = n_mask;
                    n_error     = 1'b0;
                end
            end
            default: begin
                n_mask = r_mask;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= (r_state == ST_RUN) ? r_step + STEP_W'(1) : '0;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask      <= n_mask;
        r_face_mask <= n_face_mask;
        r_error     <= n_error;
    end

    vfv_occ_ram u_occ_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (ram_req),
        .o_rd_data (rd_row)
    );

    assign o_done      = r_done;
    assign o_face_mask = r_face_mask;
    assign o_error     = r_error;

endmodule

`default_nettype wire

// ===== hdl/vfv_checker.sv =====
// ---------------------------------------------------------------------------
// vfv_checker
// port level checks of the voxel face visibility core
// ---------------------------------------------------------------------------
`default_nettype none

module vfv_checker
    import vfv_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire logic             busy,
    input  wire logic             o_done,
    input  wire logic [FACES-1:0] o_face_mask,
    input  wire logic             o_error
);

    // an accepted request either finishes at once or keeps the core busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted request neither busy nor done");

    // result only shows when the core goes idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // leaving busy always delivers the result
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_done)
        else $error("busy dropped without result");

    // out of range results carry no faces
    a_err_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_error) |-> (o_face_mask == '0))
        else $error("error result with face mask");

endmodule

bind voxel_face_visibility_core vfv_checker u_vfv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_face_mask (o_face_mask),
    .o_error     (o_error)
);

`default_nettype wire

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for voxel_face_visibility_core
// ---------------------------------------------------------------------------
// A queue of requests feeds a clocked driver on the start/busy handshake. At
// each accepted request a local occupancy grid predicts the face mask and
// error flag. A clocked monitor compares every o_done strobe with the oldest
// prediction. The run goes through several chunk dimensions, among them
// zero, one, full size and values above the maximum. Dimensions are changed
// only after all results of the previous phase have come back.
`default_nettype none

module testbench
    import vfv_pkg::*;
();

    localparam int CLK_HALF   = 5;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = 10;
    localparam int N_PHASES   = 10;
    localparam int RAND_PER_PHASE = 164;

    // index with no register behind it, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    typedef struct packed {
        t_cmd               cmd;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               solid;
        logic [FACES-1:0]   bnd;
        logic [3:0]         gap;
    } t_voxel_req;

    typedef struct packed {
        logic [FACES-1:0] mask;
        logic             err;
    } t_face_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = REG_DIM_X;
    logic [DIM_W-1:0]     i_cfg_data = '0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 o_done;
    logic [FACES-1:0]     o_face_mask;
    logic                 o_error;

    // request currently on the ports, held until the core takes it
    t_voxel_req cur_req = '0;
    logic [3:0] idle_left = '0;

    t_voxel_req   req_q[$];
    t_face_result pending_faces[$];

    // predictor state: one bit per cell, fixed stride of MAX_DIM per axis
    bit               solid_cells [MAX_DIM*MAX_DIM*MAX_DIM];
    logic [DIM_W-1:0] chunk_dim [3];

    int fail_count = 0;
    int cycle_count = 0;
    int gap_max = 15;
    int win_x, win_y, win_z;

    voxel_face_visibility_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .start            (start),
        .busy             (busy),
        .i_cmd            (cur_req.cmd),
        .i_coord_x        (cur_req.x),
        .i_coord_y        (cur_req.y),
        .i_coord_z        (cur_req.z),
        .i_solid          (cur_req.solid),
        .i_boundary_solid (cur_req.bnd),
        .o_done           (o_done),
        .o_face_mask      (o_face_mask),
        .o_error          (o_error)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // dimensions above MAX_DIM saturate
    function automatic int eff_dim(logic [DIM_W-1:0] d);
        return (int'(d) > MAX_DIM) ? MAX_DIM : int'(d);
    endfunction

    function automatic int cell_index(int x, int y, int z);
        return x + MAX_DIM * (y + MAX_DIM * z);
    endfunction

    // expected result of one request; a write updates the local grid
    function automatic t_face_result predict_faces(t_voxel_req r);
        t_face_result res;
        int dx, dy, dz, x, y, z;
        dx = eff_dim(chunk_dim[0]);
        dy = eff_dim(chunk_dim[1]);
        dz = eff_dim(chunk_dim[2]);
        x = int'(r.x);
        y = int'(r.y);
        z = int'(r.z);
        res.mask = '0;
        res.err = (x >= dx) || (y >= dy) || (z >= dz);
        if (!res.err) begin
            if (r.cmd == CMD_WRITE) begin
                solid_cells[cell_index(x, y, z)] = r.solid;
            end else begin
                // edge faces follow the boundary bits, inner faces the neighbor cell
                res.mask[FACE_PX] = (x + 1 >= dx) ? !r.bnd[FACE_PX]
                                                  : !solid_cells[cell_index(x + 1, y, z)];
                res.mask[FACE_NX] = (x == 0) ? !r.bnd[FACE_NX]
                                             : !solid_cells[cell_index(x - 1, y, z)];
                res.mask[FACE_PY] = (y + 1 >= dy) ? !r.bnd[FACE_PY]
                                                  : !solid_cells[cell_index(x, y + 1, z)];
                res.mask[FACE_NY] = (y == 0) ? !r.bnd[FACE_NY]
                                             : !solid_cells[cell_index(x, y - 1, z)];
                res.mask[FACE_PZ] = (z + 1 >= dz) ? !r.bnd[FACE_PZ]
                                                  : !solid_cells[cell_index(x, y, z + 1)];
                res.mask[FACE_NZ] = (z == 0) ? !r.bnd[FACE_NZ]
                                             : !solid_cells[cell_index(x, y, z - 1)];
            end
        end
        return res;
    endfunction

    // driver: hold a request while busy, then idle for its drawn gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            idle_left <= '0;
        end else if (!(start && busy)) begin
            if (start)
                pending_faces.push_back(predict_faces(cur_req));
            if (start && cur_req.gap != 0) begin
                start <= 1'b0;
                idle_left <= cur_req.gap - 4'd1;
            end else if (!start && idle_left != 0) begin
                idle_left <= idle_left - 4'd1;
            end else if (req_q.size() != 0) begin
                cur_req <= req_q.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: every strobe must match the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_faces.size() == 0) begin
                $error("result with no request outstanding: face_mask %0h error %0b",
                       o_face_mask, o_error);
                fail_count++;
            end else begin
                t_face_result want;
                want = pending_faces.pop_front();
                if (o_face_mask !== want.mask) begin
                    $error("face_mask mismatch: expected %0h actual %0h",
                           want.mask, o_face_mask);
                    fail_count++;
                end
                if (o_error !== want.err) begin
                    $error("error mismatch: expected %0b actual %0b", want.err, o_error);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_CAP) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic add_req(t_cmd cmd, int x, int y, int z, bit solid, int bnd);
        t_voxel_req r;
        r.cmd   = cmd;
        r.x     = COORD_W'(x);
        r.y     = COORD_W'(y);
        r.z     = COORD_W'(z);
        r.solid = solid;
        r.bnd   = FACES'(bnd);
        r.gap   = 4'($urandom_range(0, gap_max));
        req_q.push_back(r);
    endtask

    // mostly in range, often inside a small window so neighbors get dense
    function automatic int pick_coord(int lim, int base);
        int roll, v;
        roll = $urandom_range(0, 99);
        if (lim == 0 || roll < 10)
            return $urandom_range(0, MAX_DIM - 1);
        if (roll < 55) begin
            v = base + $urandom_range(0, 3);
            return (v < lim) ? v : $urandom_range(0, lim - 1);
        end
        return $urandom_range(0, lim - 1);
    endfunction

    task automatic add_random_reqs(int count);
        int dx, dy, dz, roll, bnd;
        dx = eff_dim(chunk_dim[0]);
        dy = eff_dim(chunk_dim[1]);
        dz = eff_dim(chunk_dim[2]);
        win_x = (dx > 0) ? $urandom_range(0, dx - 1) : 0;
        win_y = (dy > 0) ? $urandom_range(0, dy - 1) : 0;
        win_z = (dz > 0) ? $urandom_range(0, dz - 1) : 0;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            bnd = (roll < 25) ? 0 : (roll < 40) ? (1 << FACES) - 1
                                                : $urandom_range(0, (1 << FACES) - 1);
            add_req(($urandom_range(0, 99) < 55) ? CMD_WRITE : CMD_QUERY,
                    pick_coord(dx, win_x), pick_coord(dy, win_y), pick_coord(dz, win_z),
                    $urandom_range(0, 99) < 70, bnd);
        end
    endtask

    // sender pause: let every outstanding result come home, then settle
    task automatic wait_drained();
        do @(negedge i_clk);
        while (req_q.size() != 0 || start || idle_left != 0 || pending_faces.size() != 0);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_dim(logic [CFG_IDX_W-1:0] idx, int value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= DIM_W'(value);
        case (idx)
            REG_DIM_X: chunk_dim[0] = DIM_W'(value);
            REG_DIM_Y: chunk_dim[1] = DIM_W'(value);
            REG_DIM_Z: chunk_dim[2] = DIM_W'(value);
            default: ;
        endcase
    endtask

    initial begin
        int px[N_PHASES];
        int py[N_PHASES];
        int pz[N_PHASES];
        chunk_dim[0] = DIM_RESET;
        chunk_dim[1] = DIM_RESET;
        chunk_dim[2] = DIM_RESET;

        // dimension sets: unit chunk, zero on x, zero on z, saturating, mixed, full, small cube, random
        px = '{1, 0, 16, 31, 2, 16, 4, 0, 0, 0};
        py = '{1, 16, 16, 17, 3, 16, 4, 0, 0, 0};
        pz = '{1, 16, 0, 16, 4, 16, 4, 0, 0, 0};
        for (int p = 7; p < N_PHASES; p++) begin
            px[p] = $urandom_range(1, MAX_DIM);
            py[p] = $urandom_range(1, MAX_DIM);
            pz[p] = $urandom_range(1, MAX_DIM);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part at reset dimensions on an empty grid
        add_req(CMD_QUERY, 0, 0, 0, 0, 0);
        add_req(CMD_QUERY, 15, 15, 15, 0, 63);
        add_req(CMD_QUERY, 15, 0, 15, 0, 6'h15);
        add_req(CMD_QUERY, 7, 7, 7, 1, 63);
        // fence in the middle cell on all six sides
        add_req(CMD_WRITE, 8, 7, 7, 1, 0);
        add_req(CMD_WRITE, 6, 7, 7, 1, 0);
        add_req(CMD_WRITE, 7, 8, 7, 1, 0);
        add_req(CMD_WRITE, 7, 6, 7, 1, 0);
        add_req(CMD_WRITE, 7, 7, 8, 1, 0);
        add_req(CMD_WRITE, 7, 7, 6, 1, 63);
        add_req(CMD_QUERY, 7, 7, 7, 0, 0);
        // own occupancy does not hide faces
        add_req(CMD_WRITE, 7, 7, 7, 1, 0);
        add_req(CMD_QUERY, 7, 7, 7, 0, 0);
        add_req(CMD_QUERY, 8, 7, 7, 0, 0);
        // clearing a cell opens the face again
        add_req(CMD_WRITE, 8, 7, 7, 0, 0);
        add_req(CMD_QUERY, 7, 7, 7, 0, 6'h2a);
        add_req(CMD_WRITE, 0, 0, 0, 1, 0);
        add_req(CMD_QUERY, 1, 0, 0, 0, 63);
        add_req(CMD_WRITE, 15, 15, 15, 1, 0);
        add_req(CMD_QUERY, 14, 15, 15, 1, 0);
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            write_dim(REG_DIM_X, px[p]);
            write_dim(REG_DIM_Y, py[p]);
            write_dim(REG_DIM_Z, pz[p]);
            write_dim(REG_NONE, $urandom_range(0, 31));
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            @(negedge i_clk);

            // every third phase runs back to back with no sender gaps
            gap_max = (p % 3 == 1) ? 0 : 15;
            add_req(CMD_QUERY, 0, 0, 0, 0, 0);
            add_req(CMD_QUERY, 0, 0, 0, 0, 63);
            add_req(CMD_WRITE, 15, 15, 15, 1, 0);
            add_req(CMD_QUERY, 15, 15, 15, 0, 6'h2a);
            add_random_reqs(RAND_PER_PHASE);
            wait_drained();
        end

        if (pending_faces.size() != 0) begin
            $error("%0d results never arrived", pending_faces.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
